// ===== hdl/safs_pkg.sv =====
// Shared types and status codes for the slot allocator free stack.
`timescale 1ns / 1ps
`default_nettype none

package safs_pkg;

	// Request kinds carried in req_type.
	typedef enum logic {
		REQ_ACQUIRE = 1'b0,
		REQ_RELEASE = 1'b1
	} req_type_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NONE_FREE = 3'd1,
		ST_RANGE     = 3'd2,
		ST_NOT_LENT  = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	localparam int unsigned IDX_FIELD_W   = 8;
	localparam int unsigned COUNT_FIELD_W = 9;
	localparam int unsigned STATUS_W      = 3;

endpackage

`default_nettype wire

// ===== hdl/safs_if.sv =====
// Valid/ready channel interfaces for allocation requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface safs_req_if
	import safs_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [IDX_FIELD_W-1:0] slot_index;

	modport source (output valid, output req_type, output slot_index, input ready);
	modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

interface safs_rsp_if
	import safs_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [IDX_FIELD_W-1:0]   granted_index;
	logic [COUNT_FIELD_W-1:0] free_count;

	modport source (output valid, output status, output granted_index, output free_count,
		input ready);
	modport sink   (input valid, input status, input granted_index, input free_count,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/safs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module safs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/slot_allocator_free_stack_top.sv =====
// Top level of the slot allocator: LIFO free stack of slot indices with a lent bitmap.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The req channel carries one item per request: req_type selects acquire or release,
// slot_index names the slot to give back on a release and is ignored on an acquire.
// The rsp channel returns exactly one item per request with a status code, the slot
// index granted by a successful acquire (zero otherwise) and the number of slots on
// the free stack once the request has taken effect.
// From acceptance an item passes through the stage register, while the free-stack
// RAM delivers the entry below the top, and then through the result register. One
// item is accepted every cycle while the receiver does not stall; that rate is set by
// the stack pointer update, which closes its loop through the stage register, with a
// forwarding path covering a pop that directly follows a push.
// After reset the stack holds every slot with the highest index on top and no slot
// is lent. There is no clearing pass: a per-entry written bit makes an untouched
// stack entry read as its own position, so requests are taken from the first cycle.
// When the receiver stalls the result register holds its item, the stage register
// holds the next one, and ready on the request side drops until the result moves.

module slot_allocator_free_stack_top
	import safs_pkg::*;
#(
	parameter int unsigned SLOTS = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	safs_req_if.sink  req,
	safs_rsp_if.source rsp
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned TOP_W = $clog2(SLOTS + 1);
	localparam logic [TOP_W-1:0]         TOP_FULL   = TOP_W'(SLOTS);
	localparam logic [COUNT_FIELD_W-1:0] SLOTS_WIDE = COUNT_FIELD_W'(SLOTS);

	// Committed stack state.
	logic [TOP_W-1:0] top_q;
	logic [SLOTS-1:0] lent_q;
	logic [SLOTS-1:0] written_q;

	// Stage register.
	logic                   s1_valid_s1;
	logic                   req_type_s1;
	logic [IDX_FIELD_W-1:0] slot_index_s1;
	logic [IDX_W-1:0]       rd_addr_s1;
	logic                   seen_s1;
	logic                   byp_s1;
	logic [IDX_FIELD_W-1:0] byp_data_s1;

	// Result register.
	logic                     out_valid_q;
	status_t                  status_q;
	logic [IDX_FIELD_W-1:0]   granted_q;
	logic [COUNT_FIELD_W-1:0] count_q;

	logic                   accept;
	logic                   s1_adv;
	logic [IDX_FIELD_W-1:0] ram_rd_data;
	logic [IDX_FIELD_W-1:0] pop_slot;
	logic                   do_pop;
	logic                   do_push;
	status_t                status_c;
	logic [IDX_FIELD_W-1:0] granted_c;
	logic [TOP_W-1:0]       top_nxt_c;
	logic [TOP_W-1:0]       top_for_rd;
	logic [IDX_W-1:0]       rd_addr_c;
	logic [IDX_W-1:0]       push_addr;
	logic [IDX_W-1:0]       rel_idx;
	logic [IDX_W-1:0]       pop_idx;
	logic                   rel_in_range;
	logic                   pop_in_range;

	assign s1_adv    = s1_valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_s1 || s1_adv;
	assign accept    = req.valid && req.ready;

	assign push_addr    = IDX_W'(top_q);
	assign rel_idx      = IDX_W'(slot_index_s1);
	assign rel_in_range = {1'b0, slot_index_s1} < SLOTS_WIDE;

	// The entry under the top comes from the RAM, from the push just before, or is
	// an entry never overwritten since reset, which still holds its own position.
	always_comb begin
		if (byp_s1) begin
			pop_slot = byp_data_s1;
		end else if (seen_s1) begin
			pop_slot = ram_rd_data;
		end else begin
			pop_slot = IDX_FIELD_W'(rd_addr_s1);
		end
	end

	assign pop_idx      = IDX_W'(pop_slot);
	assign pop_in_range = {1'b0, pop_slot} < SLOTS_WIDE;

	always_comb begin
		do_pop    = 1'b0;
		do_push   = 1'b0;
		status_c  = ST_OK;
		granted_c = '0;
		top_nxt_c = top_q;
		if (req_type_s1 == REQ_ACQUIRE) begin
			if (top_q == '0) begin
				status_c = ST_NONE_FREE;
			end else begin
				do_pop    = 1'b1;
				granted_c = pop_slot;
				top_nxt_c = top_q - 1'b1;
			end
		end else begin
			if (!rel_in_range) begin
				status_c = ST_RANGE;
			end else if (!lent_q[rel_idx]) begin
				status_c = ST_NOT_LENT;
			end else if (top_q >= TOP_FULL) begin
				status_c = ST_OVERFLOW;
			end else begin
				do_push   = 1'b1;
				top_nxt_c = top_q + 1'b1;
			end
		end
	end

	// The incoming item reads the entry under the top as it stands once the item in
	// the stage register has committed.
	assign top_for_rd = s1_adv ? top_nxt_c : top_q;
	assign rd_addr_c  = IDX_W'(top_for_rd - 1'b1);

	safs_ram #(
		.WIDTH(IDX_FIELD_W),
		.DEPTH(SLOTS)
	) u_stack_ram (
		.clk    (clk),
		.we     (s1_adv && do_push),
		.wr_addr(push_addr),
		.wr_data(slot_index_s1),
		.re     (accept),
		.rd_addr(rd_addr_c),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= TOP_FULL;
			lent_q    <= '0;
			written_q <= '0;
		end else if (s1_adv) begin
			top_q <= top_nxt_c;
			if (do_pop && pop_in_range) begin
				lent_q[pop_idx] <= 1'b1;
			end
			if (do_push) begin
				lent_q[rel_idx]      <= 1'b0;
				written_q[push_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// A push committing in the accept cycle lands exactly at the address being read.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1   <= req.req_type;
			slot_index_s1 <= req.slot_index;
			rd_addr_s1    <= rd_addr_c;
			seen_s1       <= written_q[rd_addr_c];
			byp_s1        <= s1_adv && do_push;
			byp_data_s1   <= slot_index_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q  <= status_c;
			granted_q <= granted_c;
			count_q   <= COUNT_FIELD_W'(top_nxt_c);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_index = granted_q;
	assign rsp.free_count    = count_q;

	// Every slot is either on the free stack or lent, never both or neither.
	a_conservation: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(lent_q) + int'(top_q)) == int'(SLOTS))
		else $error("lent slots plus free slots differ from the pool size");

	// The request side only stalls while a finished result is blocked.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (s1_valid_s1 && out_valid_q && !rsp.ready))
		else $error("request ready dropped without a blocked result");

	// A successful acquire lowers the free count by one in the result it produces.
	a_acquire_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && req_type_s1 == REQ_ACQUIRE && status_c == ST_OK)
		|=> (count_q == COUNT_FIELD_W'($past(top_q)) - 1'b1))
		else $error("acquire did not lower the free count by one");

endmodule

`default_nettype wire

// ===== tb/tb_slot_allocator_free_stack_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the slot allocator free stack, scored against a free-stack predictor.
module tb_slot_allocator_free_stack_top;
	import safs_pkg::*;

	localparam int unsigned SLOTS        = 64;
	localparam int unsigned RANDOM_ITEMS = 760;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// One expected result item.
	typedef struct {
		status_t                  status;
		logic [IDX_FIELD_W-1:0]   granted_index;
		logic [COUNT_FIELD_W-1:0] free_count;
	} grant_t;

	// Predictor of the allocator state plus the store of results still owed by the block.
	class slot_ledger;
		logic [IDX_FIELD_W-1:0] stack_mem [SLOTS];
		bit                     lent [SLOTS];
		int unsigned            depth;
		grant_t                 owed [$];
		int unsigned            errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				stack_mem[i] = 8'(i);
				lent[i] = 1'b0;
			end
			depth = SLOTS;
			errors = 0;
		endfunction

		// Apply an accepted request to the predicted state and queue its result.
		function void log_request(req_type_t kind, logic [IDX_FIELD_W-1:0] idx);
			grant_t g;
			g.granted_index = '0;
			if (kind == REQ_ACQUIRE) begin
				if (depth == 0) begin
					g.status = ST_NONE_FREE;
				end else begin
					depth--;
					g.granted_index = stack_mem[depth];
					if (g.granted_index < SLOTS) begin
						lent[g.granted_index] = 1'b1;
					end
					g.status = ST_OK;
				end
			end else if (idx >= SLOTS) begin
				g.status = ST_RANGE;
			end else if (!lent[idx]) begin
				g.status = ST_NOT_LENT;
			end else if (depth >= SLOTS) begin
				g.status = ST_OVERFLOW;
			end else begin
				lent[idx] = 1'b0;
				stack_mem[depth] = idx;
				depth++;
				g.status = ST_OK;
			end
			g.free_count = 9'(depth);
			owed.push_back(g);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void match_result(logic [STATUS_W-1:0] st, logic [IDX_FIELD_W-1:0] gi,
			logic [COUNT_FIELD_W-1:0] fc);
			grant_t g;
			if (owed.size() == 0) begin
				$error("result with nothing expected: status %0d granted_index %0d free_count %0d",
					st, gi, fc);
				errors++;
				return;
			end
			g = owed.pop_front();
			if (st !== g.status) begin
				$error("status: expected %0d, actual %0d", g.status, st);
				errors++;
			end
			if (gi !== g.granted_index) begin
				$error("granted_index: expected %0d, actual %0d", g.granted_index, gi);
				errors++;
			end
			if (fc !== g.free_count) begin
				$error("free_count: expected %0d, actual %0d", g.free_count, fc);
				errors++;
			end
		endfunction

		// Some slot that is currently lent out, or -1 when none is.
		function int lent_slot();
			int first;
			first = $urandom_range(0, SLOTS - 1);
			for (int k = 0; k < SLOTS; k++) begin
				if (lent[(first + k) % SLOTS]) begin
					return (first + k) % SLOTS;
				end
			end
			return -1;
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned cycles;
	slot_ledger  book = new();

	safs_req_if req ();
	safs_rsp_if rsp ();

	slot_allocator_free_stack_top #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a run that reaches the cycle limit is reported as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side. Values are read right after the edge, before any update of this edge
	// lands, so they are exactly what the handshake saw. Ready is dropped at random, about
	// 9 times in a hundred, unless the quiet stretch is on.
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			book.match_result(rsp.status, rsp.granted_index, rsp.free_count);
		end
		rsp.ready <= steady || ($urandom_range(0, 99) >= 9);
	end

	// Offer one item and hold it until the block takes it. Valid is not lowered after an
	// acceptance here, so a back-to-back item keeps it high without a second update.
	task automatic issue_request(input req_type_t kind, input logic [IDX_FIELD_W-1:0] idx);
		while (!steady && $urandom_range(0, 99) < 9) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.req_type   <= kind;
		req.slot_index <= idx;
		do @(posedge clk); while (!req.ready);
		book.log_request(kind, idx);
	endtask

	initial begin
		int                     s;
		int unsigned            acq_pct;
		int unsigned            pick;
		logic [IDX_FIELD_W-1:0] idx;

		cycles         = 0;
		steady         = 1'b0;
		acq_pct        = 50;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.req_type   = REQ_ACQUIRE;
		req.slot_index = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Releases before any acquire: out of range just past the last slot,
		// at 8'h80 and at the top of the field, then slots that were never lent.
		issue_request(REQ_RELEASE, 8'(SLOTS));
		issue_request(REQ_RELEASE, 8'hFF);
		issue_request(REQ_RELEASE, 8'h80);
		issue_request(REQ_RELEASE, 8'h00);
		issue_request(REQ_RELEASE, 8'(SLOTS - 1));
		// Acquires hand out the top of the stack; the index field is ignored, so it
		// carries alternating patterns.
		issue_request(REQ_ACQUIRE, 8'hAA);
		issue_request(REQ_ACQUIRE, 8'h55);
		// A release followed by a double release of the same slot.
		issue_request(REQ_RELEASE, 8'(SLOTS - 1));
		issue_request(REQ_RELEASE, 8'(SLOTS - 1));
		// LIFO order: the slot just pushed comes straight back.
		issue_request(REQ_ACQUIRE, 8'hFF);
		issue_request(REQ_RELEASE, 8'(SLOTS - 2));
		issue_request(REQ_ACQUIRE, 8'h00);
		issue_request(REQ_ACQUIRE, 8'h7F);
		issue_request(REQ_RELEASE, 8'(SLOTS - 2));
		issue_request(REQ_RELEASE, 8'(SLOTS - 1));
		issue_request(REQ_RELEASE, 8'(SLOTS - 3));
		issue_request(REQ_RELEASE, 8'h01);

		// Drain the pool past empty so that acquires report none free, then give every
		// slot back in random order and try one more release on a full stack.
		for (int i = 0; i < SLOTS + 3; i++) begin
			issue_request(REQ_ACQUIRE, 8'($urandom));
		end
		s = book.lent_slot();
		while (s >= 0) begin
			issue_request(REQ_RELEASE, 8'(s));
			s = book.lent_slot();
		end
		issue_request(REQ_RELEASE, 8'($urandom_range(0, SLOTS - 1)));

		// Random part. The mix of acquires and releases shifts every 60 items so the
		// stack swings between empty and full. Most releases return a lent slot; the rest
		// are random in-range slots, which may not be lent, and indexes from the whole field.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				case ($urandom_range(0, 2))
					0: acq_pct = 85;
					1: acq_pct = 15;
					default: acq_pct = 50;
				endcase
			end
			steady <= (n >= 250 && n < 450);
			// Once, let every owed result come home before going on.
			if (n == 550) begin
				req.valid <= 1'b0;
				while (book.pending() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 99) < acq_pct) begin
				issue_request(REQ_ACQUIRE, 8'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				s = book.lent_slot();
				if (pick < 70 && s >= 0) begin
					idx = 8'(s);
				end else if (pick < 85) begin
					idx = 8'($urandom_range(0, SLOTS - 1));
				end else begin
					idx = 8'($urandom_range(0, 255));
				end
				issue_request(REQ_RELEASE, idx);
			end
		end
		req.valid <= 1'b0;

		// Wait for the last results, then keep watching to catch any stray item.
		while (book.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/safs_pkg.sv
hdl/safs_if.sv
hdl/safs_ram.sv
hdl/slot_allocator_free_stack_top.sv
tb/tb_slot_allocator_free_stack_top.sv
